FILE: rtl/tfv_pkg.sv
// shared types, constants and tables of the target follow velocity block
package tfv_pkg;

  localparam int POS_W       = 16;
  localparam int VEL_W       = 20;
  localparam int GAIN_W      = 12;
  localparam int DIST_W      = 15;
  localparam int MAXD_W      = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int SQRT_STEPS  = 16;
  localparam int MAX_STAGES  = 24;
  localparam int PRESCALE_SH = 14;
  localparam int CV_W        = 32;
  localparam int Z_W         = 34;
  localparam int SQ_W        = 32;

  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

  // atan(2^-i) truncated to 30 fraction bits
  localparam logic [29:0] ATAN_Q30 [MAX_STAGES] = '{
    30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158,
    30'd67021686,  30'd33543515,  30'd16775850,  30'd8388437,
    30'd4194282,   30'd2097149,   30'd1048575,   30'd524287,
    30'd262143,    30'd131071,    30'd65535,     30'd32767,
    30'd16383,     30'd8191,      30'd4095,      30'd2047,
    30'd1023,      30'd511,       30'd255,       30'd127
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TRANS_GAIN  = 3'd0,
    REG_ANG_GAIN    = 3'd1,
    REG_TARGET_DIST = 3'd2,
    REG_MIN_DIST    = 3'd3,
    REG_MAX_DIST    = 3'd4,
    REG_LAT_LIMIT   = 3'd5
  } tfv_reg_e;

  // state carried through the cordic and square root stages
  typedef struct packed {
    logic signed [CV_W-1:0] cx;
    logic signed [CV_W-1:0] cy;
    logic signed [Z_W-1:0]  z;
    logic [SQ_W-1:0]        rem;
    logic [SQ_W-1:0]        root;
    logic                   origin;
    logic                   lat_ok;
  } tfv_core_t;

endpackage

FILE: rtl/tfv_if.sv
// valid/ready channel interfaces for position, velocity and configuration
interface tfv_pos_if import tfv_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;

  modport source (output valid, output pos_x, output pos_y, input ready);
  modport sink (input valid, input pos_x, input pos_y, output ready);
endinterface

interface tfv_vel_if import tfv_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VEL_W-1:0] linear_velocity;
  logic signed [VEL_W-1:0] angular_velocity;
  logic                    in_window;

  modport source (output valid, output linear_velocity, output angular_velocity,
                  output in_window, input ready);
  modport sink (input valid, input linear_velocity, input angular_velocity,
                input in_window, output ready);
endinterface

interface tfv_cfg_if import tfv_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/tfv_core_stage.sv
// one pipeline stage: a cordic vectoring step and a square root digit step, each enabled by parameter
module tfv_core_stage import tfv_pkg::*; #(
  parameter int STAGE  = 0,
  parameter bit ROT_EN = 1'b1
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      valid_i,
  input  tfv_core_t data_i,
  output logic      valid_o,
  output tfv_core_t data_o
);

  localparam bit            SQRT_EN = (STAGE < SQRT_STEPS);
  localparam int            SQ_SH   = SQRT_EN ? (2 * (SQRT_STEPS - 1 - STAGE)) : 0;
  localparam logic [SQ_W-1:0] SQ_BIT = SQ_W'(1) << SQ_SH;
  localparam logic signed [Z_W-1:0] ATAN_Z = $signed({4'b0, ATAN_Q30[STAGE]});

  logic signed [CV_W-1:0] dx;
  logic signed [CV_W-1:0] dy;
  logic [SQ_W:0]          trial;
  tfv_core_t              data_d;
  tfv_core_t              data_q;
  logic                   valid_q;

  assign dx    = data_i.cy >>> STAGE;
  assign dy    = data_i.cx >>> STAGE;
  assign trial = {1'b0, data_i.root} + {1'b0, SQ_BIT};

  always_comb begin
    data_d = data_i;
    if (ROT_EN) begin
      // steer toward y = 0
      if (!data_i.cy[CV_W-1]) begin
        data_d.cx = data_i.cx + dx;
        data_d.cy = data_i.cy - dy;
        data_d.z  = data_i.z + ATAN_Z;
      end else begin
        data_d.cx = data_i.cx - dx;
        data_d.cy = data_i.cy + dy;
        data_d.z  = data_i.z - ATAN_Z;
      end
    end
    if (SQRT_EN) begin
      if ({1'b0, data_i.rem} >= trial) begin
        data_d.rem  = data_i.rem - trial[SQ_W-1:0];
        data_d.root = (data_i.root >> 1) + SQ_BIT;
      end else begin
        data_d.root = data_i.root >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: rtl/target_follow_velocity_core.sv
// pursuit controller: distance and bearing of a target to velocity commands
//
//  channel | dir | fields                                          | handshake
//  pos_i   | in  | pos_x, pos_y (signed Q4.12)                     | valid/ready
//  vel_o   | out | linear_velocity, angular_velocity, in_window    | valid/ready
//  cfg_i   | in  | index, data (register write)                    | valid/ready
//
// one item per cycle sustained while vel_o is ready; the depth is set by the chain
// of cordic / square root stages (at most one step of each per stage)
// reset clears valid bits and restores the register defaults; cfg_i is always ready
// a one-item skid register behind the last stage takes the result that vel_o
// refuses, so pos_i stays ready during the first stall cycle; while the skid
// holds an item the whole pipeline and pos_i hold still
module target_follow_velocity_core import tfv_pkg::*; #(
  parameter int CORDIC_STAGES = 16,
  parameter int FRAC_BITS     = 12
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tfv_pos_if.sink   pos_i,
  tfv_vel_if.source vel_o,
  tfv_cfg_if.sink   cfg_i
);

  // core depth covers both the cordic steps and the 16 root digits
  localparam int CORE  = (CORDIC_STAGES > SQRT_STEPS) ? CORDIC_STAGES : SQRT_STEPS;
  localparam int ANG_W = FRAC_BITS + 3;
  localparam int LIN_W = MAXD_W + 1;
  localparam int LP_W  = LIN_W + GAIN_W + 1;
  localparam int AP_W  = ANG_W + GAIN_W + 1;
  localparam logic signed [Z_W-1:0] ANG_RND = Z_W'(1) <<< (29 - FRAC_BITS);
  localparam logic signed [47:0] OUT_MAX = (48'sd1 <<< (VEL_W - 1)) - 48'sd1;
  localparam logic signed [47:0] OUT_MIN = -(48'sd1 <<< (VEL_W - 1));

  // round half up by 8 bits, then clamp to the output range
  function automatic logic signed [VEL_W-1:0] round_sat(input logic signed [47:0] p);
    logic signed [47:0] r;
    r = (p + 48'sd128) >>> 8;
    if (r > OUT_MAX) begin
      round_sat = OUT_MAX[VEL_W-1:0];
    end else if (r < OUT_MIN) begin
      round_sat = OUT_MIN[VEL_W-1:0];
    end else begin
      round_sat = r[VEL_W-1:0];
    end
  endfunction

  // configuration registers
  logic [GAIN_W-1:0] tgain_q;
  logic [GAIN_W-1:0] again_q;
  logic [DIST_W-1:0] target_q;
  logic [DIST_W-1:0] min_q;
  logic [MAXD_W-1:0] max_q;
  logic [DIST_W-1:0] lat_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgain_q  <= GAIN_W'(512);
      again_q  <= GAIN_W'(896);
      target_q <= DIST_W'(4096);
      min_q    <= DIST_W'(2458);
      max_q    <= MAXD_W'(7373);
      lat_q    <= DIST_W'(2048);
    end else if (cfg_i.valid) begin
      unique case (tfv_reg_e'(cfg_i.index))
        REG_TRANS_GAIN:  tgain_q  <= cfg_i.data[GAIN_W-1:0];
        REG_ANG_GAIN:    again_q  <= cfg_i.data[GAIN_W-1:0];
        REG_TARGET_DIST: target_q <= cfg_i.data[DIST_W-1:0];
        REG_MIN_DIST:    min_q    <= cfg_i.data[DIST_W-1:0];
        REG_MAX_DIST:    max_q    <= cfg_i.data[MAXD_W-1:0];
        REG_LAT_LIMIT:   lat_q    <= cfg_i.data[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  // whole pipeline moves unless the skid register holds a refused item
  logic skid_full_q;
  logic en;

  assign en          = !skid_full_q;
  assign pos_i.ready = en;

  // stage 0: squares, prescale, quadrant fold, lateral check
  logic signed [2*POS_W-1:0] xx_full;
  logic signed [2*POS_W-1:0] yy_full;
  logic signed [CV_W-1:0]    cx0;
  logic signed [CV_W-1:0]    cy0;
  logic [POS_W-1:0]          ay;
  tfv_core_t                 s0_d;
  tfv_core_t                 s0_q;
  logic [2*POS_W-2:0]        s0_xx_q;
  logic [2*POS_W-2:0]        s0_yy_q;
  logic                      s0_v_q;

  assign xx_full = pos_i.pos_x * pos_i.pos_x;
  assign yy_full = pos_i.pos_y * pos_i.pos_y;
  assign cx0     = {{(CV_W-POS_W-PRESCALE_SH){pos_i.pos_x[POS_W-1]}}, pos_i.pos_x,
                    {PRESCALE_SH{1'b0}}};
  assign cy0     = {{(CV_W-POS_W-PRESCALE_SH){pos_i.pos_y[POS_W-1]}}, pos_i.pos_y,
                    {PRESCALE_SH{1'b0}}};
  assign ay      = pos_i.pos_y[POS_W-1] ? POS_W'(-pos_i.pos_y) : pos_i.pos_y;

  always_comb begin
    s0_d        = '0;
    s0_d.cx     = cx0;
    s0_d.cy     = cy0;
    s0_d.origin = (pos_i.pos_x == '0) && (pos_i.pos_y == '0);
    s0_d.lat_ok = ay < {1'b0, lat_q};
    // left half plane: turn a quarter toward the x axis first
    if (pos_i.pos_x[POS_W-1]) begin
      if (!pos_i.pos_y[POS_W-1]) begin
        s0_d.cx = cy0;
        s0_d.cy = -cx0;
        s0_d.z  = $signed({3'b0, HALF_PI_Q30});
      end else begin
        s0_d.cx = -cy0;
        s0_d.cy = cx0;
        s0_d.z  = -$signed({3'b0, HALF_PI_Q30});
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
    end else if (en) begin
      s0_v_q <= pos_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_q    <= s0_d;
      s0_xx_q <= xx_full[2*POS_W-2:0];
      s0_yy_q <= yy_full[2*POS_W-2:0];
    end
  end

  // stage 1: sum of squares seeds the root
  tfv_core_t core_q [CORE+1];
  logic      core_v [CORE+1];
  tfv_core_t s1_d;

  always_comb begin
    s1_d      = s0_q;
    s1_d.rem  = SQ_W'(s0_xx_q) + SQ_W'(s0_yy_q);
    s1_d.root = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      core_v[0] <= 1'b0;
    end else if (en) begin
      core_v[0] <= s0_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      core_q[0] <= s1_d;
    end
  end

  // cordic vectoring and square root, at most one step of each per stage
  for (genvar k = 0; k < CORE; k++) begin : g_core
    tfv_core_stage #(
      .STAGE  (k),
      .ROT_EN (k < CORDIC_STAGES)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (core_v[k]),
      .data_i  (core_q[k]),
      .valid_o (core_v[k+1]),
      .data_o  (core_q[k+1])
    );
  end

  // stage a: window test, distance error, rounded bearing
  tfv_core_t               fin;
  logic [MAXD_W-1:0]       distance;
  logic signed [Z_W-1:0]   ang_full;
  logic                    a_v_q;
  logic                    a_win_q;
  logic signed [LIN_W-1:0] a_lin_q;
  logic signed [ANG_W-1:0] a_ang_q;

  assign fin      = core_q[CORE];
  assign distance = fin.root[MAXD_W-1:0];
  assign ang_full = (fin.z + ANG_RND) >>> (30 - FRAC_BITS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else if (en) begin
      a_v_q <= core_v[CORE];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_win_q <= (distance >= {1'b0, min_q}) && (distance <= max_q) && fin.lat_ok;
      a_lin_q <= $signed({1'b0, distance}) - $signed({2'b0, target_q});
      a_ang_q <= fin.origin ? '0 : ang_full[ANG_W-1:0];
    end
  end

  // stage b: gain products
  logic                   b_v_q;
  logic                   b_win_q;
  logic signed [LP_W-1:0] b_lin_q;
  logic signed [AP_W-1:0] b_ang_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
    end else if (en) begin
      b_v_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_win_q <= a_win_q;
      b_lin_q <= LP_W'(a_lin_q * $signed({1'b0, tgain_q}));
      b_ang_q <= AP_W'(a_ang_q * $signed({1'b0, again_q}));
    end
  end

  // stage c: round, saturate, zero outside the window
  logic                    c_v_q;
  logic                    c_win_q;
  logic signed [VEL_W-1:0] c_lin_q;
  logic signed [VEL_W-1:0] c_ang_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_v_q <= 1'b0;
    end else if (en) begin
      c_v_q <= b_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_win_q <= b_win_q;
      c_lin_q <= b_win_q ? round_sat(48'(b_lin_q)) : '0;
      c_ang_q <= b_win_q ? round_sat(48'(b_ang_q)) : '0;
    end
  end

  // skid register: holds the last stage's item when vel_o refuses it
  logic                    skid_win_q;
  logic signed [VEL_W-1:0] skid_lin_q;
  logic signed [VEL_W-1:0] skid_ang_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_full_q <= 1'b0;
    end else if (!skid_full_q) begin
      skid_full_q <= c_v_q && !vel_o.ready;
    end else if (vel_o.ready) begin
      skid_full_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_full_q) begin
      skid_win_q <= c_win_q;
      skid_lin_q <= c_lin_q;
      skid_ang_q <= c_ang_q;
    end
  end

  assign vel_o.valid            = skid_full_q || c_v_q;
  assign vel_o.linear_velocity  = skid_full_q ? skid_lin_q : c_lin_q;
  assign vel_o.angular_velocity = skid_full_q ? skid_ang_q : c_ang_q;
  assign vel_o.in_window        = skid_full_q ? skid_win_q : c_win_q;

endmodule

FILE: rtl/tfv_checker.sv
// port level checks of the target follow velocity block and their binding
module tfv_checker import tfv_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    pos_valid_i,
  input logic                    pos_ready_i,
  input logic                    vel_valid_i,
  input logic                    vel_ready_i,
  input logic signed [VEL_W-1:0] lin_i,
  input logic signed [VEL_W-1:0] ang_i,
  input logic                    win_i
);

  // a refused result stays offered
  a_vel_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vel_valid_i && !vel_ready_i |=> vel_valid_i)
    else $error("result dropped while stalled");

  // a refused result keeps its payload
  a_vel_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vel_valid_i && !vel_ready_i |=> $stable(lin_i) && $stable(ang_i) && $stable(win_i))
    else $error("result changed while stalled");

  // commands are zero outside the window
  a_zero_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vel_valid_i && !win_i |-> lin_i == '0 && ang_i == '0)
    else $error("nonzero command outside window");

  // input is refused only while a result waits at the output
  a_ready_why: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pos_ready_i |-> vel_valid_i)
    else $error("input refused with no pending result");

  // once the waiting result is taken the input opens again
  a_ready_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vel_valid_i && vel_ready_i && !pos_ready_i |=> pos_ready_i)
    else $error("input stays blocked after drain");

  logic unused_pos_valid;
  assign unused_pos_valid = pos_valid_i;

endmodule

bind target_follow_velocity_core tfv_checker u_tfv_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .pos_valid_i (pos_i.valid),
  .pos_ready_i (pos_i.ready),
  .vel_valid_i (vel_o.valid),
  .vel_ready_i (vel_o.ready),
  .lin_i       (vel_o.linear_velocity),
  .ang_i       (vel_o.angular_velocity),
  .win_i       (vel_o.in_window)
);
